// ----- sv/sha256_stream_hash_core_assert.svh -----
// assertion macros for the sha256 stream hash core
// used by the port checker only
`ifndef SHA256_STREAM_HASH_CORE_ASSERT_SVH
`define SHA256_STREAM_HASH_CORE_ASSERT_SVH

// implication checked every clock outside reset
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/sha256_pkg.sv -----
// shared types, constants and round functions for the sha256 stream hash
// no dependencies
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // pad phases of a finish item
    typedef enum logic [1:0] {
        PH_NONE,
        PH_EXTRA,
        PH_FINAL
    } t_phase;

    localparam logic REQ_ABSORB = 1'b0;
    localparam logic REQ_FINISH = 1'b1;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef logic [31:0] t_word;

    // control from sequencer to round unit
    typedef struct packed {
        logic init;
        logic load;
        logic round;
        logic add;
        logic reset_hash;
    } t_round_ctrl;

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic t_word round_k(input logic [5:0] r);
        t_word k [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        round_k = k[r];
    endfunction

    function automatic t_word init_hash(input logic [2:0] i);
        t_word h [8] = '{
            32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
            32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        init_hash = h[i];
    endfunction

endpackage

// ----- sv/sha256_stream_hash_core.sv -----
// top level of the sha256 stream hash: byte buffer, sequencer, output register
// depends on sha256_pkg and sha256_round
//
// usage:
//   input channel carries one item: i_req_type 0 absorbs i_data_byte,
//   1 finishes the message. the block stalls the input while it works.
//   an absorb only stores the byte, except the 64th byte of a block, which
//   also runs compression: 16 word loads, 64 rounds on the single shared
//   round unit and one hash add.
//   a finish pads, compresses one block (two when fewer than 9 bytes
//   remain), then emits eight items o_digest_word / o_word_index /
//   o_last_word, H0 first, one per cycle when not stalled.
//   the round unit, one round per cycle, sets the compression time.
//   a stall on the output holds the current digest word steady.
//   reset (synchronous, active low) reloads the initial hash and clears
//   the byte count and fill count; buffer contents are left as they are.
//   after finish the block returns to the initial hash, empty message.
module sha256_stream_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256_pkg::t_state    r_state, n_state;
    sha256_pkg::t_phase    r_phase, n_phase;
    sha256_pkg::t_round_ctrl n_ctrl;
    logic [31:0] r_buf [16];
    logic [5:0]  r_fill;
    logic [60:0] r_total;
    logic [6:0]  r_cnt, n_cnt;
    logic [2:0]  r_idx;
    logic        r_extra;
    logic [31:0] n_load_word;
    logic [31:0] n_buf_word;
    logic [63:0] n_bits;
    logic        n_acc, n_out_take;
    logic [5:0]  n_pos;

    assign n_acc      = i_valid && !o_stall;
    assign n_out_take = o_valid && !i_stall;
    assign n_bits     = {r_total, 3'b000};

    // padded byte at a block position while loading
    function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [7:0] b,
                                            input sha256_pkg::t_phase ph,
                                            input logic [5:0] fill, input logic [63:0] bits,
                                            input logic extra);
        logic [7:0] v;
        v = b;
        if (ph == sha256_pkg::PH_FINAL) begin
            if (p >= 6'd56) begin
                v = bits[8*(63 - p) +: 8];
            end else if (!extra && p == fill) begin
                v = sha256_pkg::PAD_MARK;
            end else if (extra || p > fill) begin
                v = 8'h00;
            end
        end else if (ph == sha256_pkg::PH_EXTRA) begin
            if (p == fill) v = sha256_pkg::PAD_MARK;
            else if (p > fill) v = 8'h00;
        end
        pad_byte = v;
    endfunction

    // load word from the buffer at word r_cnt
    always_comb begin
        n_pos = {r_cnt[3:0], 2'b00};
        n_buf_word = r_buf[r_cnt[3:0]];
        n_load_word = {pad_byte(n_pos, n_buf_word[31:24], r_phase, r_fill, n_bits, r_extra),
                       pad_byte(n_pos | 6'd1, n_buf_word[23:16], r_phase, r_fill, n_bits,
                                r_extra),
                       pad_byte(n_pos | 6'd2, n_buf_word[15:8], r_phase, r_fill, n_bits,
                                r_extra),
                       pad_byte(n_pos | 6'd3, n_buf_word[7:0], r_phase, r_fill, n_bits,
                                r_extra)};
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        case (r_state)
            sha256_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (n_acc) begin
                    if (i_req_type == sha256_pkg::REQ_FINISH) begin
                        n_state = sha256_pkg::ST_LOAD;
                        n_phase = (r_fill >= 6'd56) ? sha256_pkg::PH_EXTRA
                                                    : sha256_pkg::PH_FINAL;
                    end else if (r_fill == 6'd63) begin
                        n_state = sha256_pkg::ST_LOAD;
                        n_phase = sha256_pkg::PH_NONE;
                    end
                end
            end
            sha256_pkg::ST_LOAD: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd15) begin
                    n_state = sha256_pkg::ST_ROUND;
                    n_cnt   = '0;
                end
            end
            sha256_pkg::ST_ROUND: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd63) n_state = sha256_pkg::ST_ADD;
            end
            sha256_pkg::ST_ADD: begin
                n_cnt = '0;
                if (r_phase == sha256_pkg::PH_EXTRA) begin
                    n_state = sha256_pkg::ST_LOAD;
                    n_phase = sha256_pkg::PH_FINAL;
                end else if (r_phase == sha256_pkg::PH_FINAL) begin
                    n_state = sha256_pkg::ST_EMIT;
                end else begin
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_EMIT: begin
                if (n_out_take && r_idx == 3'd7) begin
                    n_state = sha256_pkg::ST_IDLE;
                    n_phase = sha256_pkg::PH_NONE;
                end
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        n_ctrl = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            sha256_pkg::ST_IDLE:  o_stall = 1'b0;
            sha256_pkg::ST_LOAD: begin
                n_ctrl.load = 1'b1;
                n_ctrl.init = (r_cnt == 7'd0);
            end
            sha256_pkg::ST_ROUND: n_ctrl.round = 1'b1;
            sha256_pkg::ST_ADD:   n_ctrl.add = 1'b1;
            sha256_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                n_ctrl.reset_hash = n_out_take && r_idx == 3'd7;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::ST_IDLE;
            r_phase <= sha256_pkg::PH_NONE;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_total <= '0;
            r_idx   <= '0;
            r_extra <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            if (r_state == sha256_pkg::ST_IDLE && n_acc) begin
                if (i_req_type == sha256_pkg::REQ_ABSORB) begin
                    r_fill  <= r_fill + 6'd1;
                    r_total <= r_total + 61'd1;
                end
                r_extra <= 1'b0;
            end
            if (r_state == sha256_pkg::ST_ADD && r_phase == sha256_pkg::PH_EXTRA) begin
                r_extra <= 1'b1;
            end
            if (n_out_take) begin
                r_idx <= r_idx + 3'd1;
                if (r_idx == 3'd7) begin
                    r_fill  <= '0;
                    r_total <= '0;
                end
            end
        end
    end

    // byte buffer, held as 16 big-endian words
    always_ff @(posedge i_clk) begin
        if (r_state == sha256_pkg::ST_IDLE && n_acc && i_req_type == sha256_pkg::REQ_ABSORB) begin
            r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_data_byte;
        end
    end

    sha256_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (n_ctrl),
        .i_rnd       (r_cnt[5:0]),
        .i_load_word (n_load_word),
        .i_hash_sel  (r_idx),
        .o_hash_word (o_digest_word)
    );

    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == 3'd7);

endmodule

// ----- sv/sha256_round.sv -----
// one sha256 round unit with schedule window, working and hash registers
// depends on sha256_pkg
module sha256_round (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sha256_pkg::t_round_ctrl i_ctrl,
    input  logic [5:0]              i_rnd,
    input  sha256_pkg::t_word       i_load_word,
    input  logic [2:0]              i_hash_sel,
    output sha256_pkg::t_word       o_hash_word
);

    sha256_pkg::t_word r_h [8];
    sha256_pkg::t_word r_v [8];
    sha256_pkg::t_word r_w [16];

    sha256_pkg::t_word n_w, n_t1, n_t2, n_s0, n_s1;

    // schedule word: window shifts, oldest at index 0
    always_comb begin
        n_s0 = sha256_pkg::rotr(r_w[1], 7) ^ sha256_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        n_s1 = sha256_pkg::rotr(r_w[14], 17) ^ sha256_pkg::rotr(r_w[14], 19)
             ^ (r_w[14] >> 10);
        if (i_rnd < 6'd16) begin
            n_w = r_w[0];
        end else begin
            n_w = n_s1 + r_w[9] + n_s0 + r_w[0];
        end
    end

    // round compression
    always_comb begin
        n_t1 = r_v[7] + (sha256_pkg::rotr(r_v[4], 6) ^ sha256_pkg::rotr(r_v[4], 11)
             ^ sha256_pkg::rotr(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha256_pkg::round_k(i_rnd) + n_w;
        n_t2 = (sha256_pkg::rotr(r_v[0], 2) ^ sha256_pkg::rotr(r_v[0], 13)
             ^ sha256_pkg::rotr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // hash words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.reset_hash) begin
            for (int i = 0; i < 8; i++) r_h[i] <= sha256_pkg::init_hash(3'(i));
        end else if (i_ctrl.add) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    // working variables and window
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctrl.round) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + n_t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= n_t1 + n_t2;
        end
        if (i_ctrl.load || i_ctrl.round) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= i_ctrl.load ? i_load_word : n_w;
        end
    end

    assign o_hash_word = r_h[i_hash_sel];

endmodule

// ----- sv/sha256_check.sv -----
// port checker for the sha256 stream hash core, bound to the top level
// depends on sha256_stream_hash_core_assert.svh
`include "sha256_stream_hash_core_assert.svh"

module sha256_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    `SHA_ASSERT_IMP(a_no_take_while_out, i_clk, i_rst_n, o_valid, o_stall)
    `SHA_ASSERT_IMP(a_last_matches, i_clk, i_rst_n, o_valid, o_last_word == (o_word_index == 3'd7))
    `SHA_ASSERT_NEXT(a_index_steps, i_clk, i_rst_n, o_valid && !i_stall && !o_last_word,
                     o_valid && o_word_index == $past(o_word_index) + 3'd1)
    `SHA_ASSERT_NEXT(a_word_holds, i_clk, i_rst_n, o_valid && i_stall,
                     o_valid && $stable(o_digest_word))

endmodule

bind sha256_stream_hash_core sha256_check u_check (.*);
